[sv/matrix4x4_multiply_macros.svh]
// Assertion macros shared by the 4x4 matrix multiplier RTL.
// Each macro expects signals named clock and reset in the calling module.
`ifndef MATRIX4X4_MULTIPLY_MACROS_SVH
`define MATRIX4X4_MULTIPLY_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define MM4_ASSERT_NOW(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define MM4_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

[sv/mm4_pkg.sv]
// Package for the 4x4 matrix multiplier: widths, row and bank types, control structs.
// No dependencies; imported by every module of the block.
`default_nettype none

package mm4_pkg;

   localparam int DATA_W = 32;
   localparam int PROD_W = 2 * DATA_W;
   // four full-width products summed exactly need two guard bits
   localparam int ACC_W  = PROD_W + 2;
   localparam int DIM    = 4;

   localparam logic [1:0] ROW_FIRST = 2'd0;
   localparam logic [1:0] ROW_LAST  = 2'd3;

   typedef logic [DIM-1:0][DATA_W-1:0] mm4_row_type;

   // store write from the front end into the back end's banked stores
   typedef struct packed {
      logic        we;
      logic        bank;
      logic [1:0]  row;
      mm4_row_type a_row;
      mm4_row_type b_row;
   } mm4_wr_type;

   // back end job status; done pulses when a bank's last read has been issued
   typedef struct packed {
      logic active;
      logic done;
      logic bank;
   } mm4_status_type;

endpackage

`default_nettype wire

[sv/matrix4x4_multiply.sv]
// 4x4 fixed-point matrix multiplier, P = A * B, signed Q16.16 by default.
// Request channel (req_): one row of A and the same row of B per request, rows 0..3
// in order. Response channel (rsp_): one product row per response, rows 0..3 in order,
// rsp_last_row on row 3, rsp_saturated if any element of that row was clipped.
// Both channels: a transfer happens on a rising edge with valid high and stall low.
// After the fourth request is taken, the job passes through the job queue, the sequencer,
// the store read, product, accumulator and result registers to the first product row.
// The back end's four multiply-accumulate lanes work through each product row one term
// at a time, and the back end takes the next job from the queue only once it has issued
// the last term of the current matrix.
// Two store banks let the next matrix load while the current one is multiplied.
// Reset (synchronous) empties the queue and the pipeline and restarts at row 0;
// store contents are not cleared.
// A stalled response freezes the back end's store reads and pipeline; the front end keeps
// loading the free bank and then stalls requests until the back end releases a bank.
// Depends on mm4_pkg, mm4_front, mm4_queue, mm4_back and the assertion macro header.
`default_nettype none
`include "matrix4x4_multiply_macros.svh"

module matrix4x4_multiply import mm4_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic signed [DATA_W-1:0] req_a_elem0,
   input  wire logic signed [DATA_W-1:0] req_a_elem1,
   input  wire logic signed [DATA_W-1:0] req_a_elem2,
   input  wire logic signed [DATA_W-1:0] req_a_elem3,
   input  wire logic signed [DATA_W-1:0] req_b_elem0,
   input  wire logic signed [DATA_W-1:0] req_b_elem1,
   input  wire logic signed [DATA_W-1:0] req_b_elem2,
   input  wire logic signed [DATA_W-1:0] req_b_elem3,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic signed [DATA_W-1:0]      rsp_p_elem0,
   output logic signed [DATA_W-1:0]      rsp_p_elem1,
   output logic signed [DATA_W-1:0]      rsp_p_elem2,
   output logic signed [DATA_W-1:0]      rsp_p_elem3,
   output logic [1:0]                    rsp_row_index,
   output logic                          rsp_last_row,
   output logic                          rsp_saturated
);

   mm4_row_type    a_row, b_row, p_row;
   mm4_wr_type     st_wr;
   mm4_status_type bk_status;
   logic           q_push, q_push_bank, q_full;
   logic           q_pop, q_pop_bank, q_empty;

   // gather request columns into rows, column 0 in the low word
   assign a_row = {req_a_elem3, req_a_elem2, req_a_elem1, req_a_elem0};
   assign b_row = {req_b_elem3, req_b_elem2, req_b_elem1, req_b_elem0};

   // front end: count rows, write the free bank, post a job on the fourth row
   mm4_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .a_row     (a_row),
      .b_row     (b_row),
      .q_push    (q_push),
      .q_bank    (q_push_bank),
      .q_full    (q_full),
      .status    (bk_status),
      .wr        (st_wr)
   );

   // job queue: decouple loading from multiplying
   mm4_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_bank (q_push_bank),
      .full      (q_full),
      .pop       (q_pop),
      .pop_bank  (q_pop_bank),
      .empty     (q_empty)
   );

   // back end: multiply-accumulate lanes and the response register
   mm4_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .wr        (st_wr),
      .q_empty   (q_empty),
      .q_bank    (q_pop_bank),
      .q_pop     (q_pop),
      .status    (bk_status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .p_row     (p_row),
      .row_index (rsp_row_index),
      .last_row  (rsp_last_row),
      .saturated (rsp_saturated)
   );

   // spread the product row over the response ports
   assign rsp_p_elem0 = p_row[0];
   assign rsp_p_elem1 = p_row[1];
   assign rsp_p_elem2 = p_row[2];
   assign rsp_p_elem3 = p_row[3];

   // a job is only posted when the queue has room
   `MM4_ASSERT_NOW(a_push_room, q_push, !q_full, "job posted to a full queue")
   // never overwrite the bank the back end is reading
   `MM4_ASSERT_NOW(a_bank_safe, st_wr.we && bk_status.active, st_wr.bank != bk_status.bank, "write to active bank")
   // product rows leave in order within a matrix
   `MM4_ASSERT_NEXT(a_row_order, rsp_valid && !rsp_stall && !rsp_last_row, !rsp_valid || (rsp_row_index == 2'($past(rsp_row_index) + 2'd1)), "product rows out of order")

endmodule

`default_nettype wire

[sv/mm4_front.sv]
// Front end of the 4x4 matrix multiplier: takes row requests, steers them into a bank.
// Depends on mm4_pkg; feeds mm4_queue with completed banks and mm4_back with writes.
`default_nettype none

module mm4_front import mm4_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   input  wire mm4_row_type    a_row,
   input  wire mm4_row_type    b_row,
   output logic                q_push,
   output logic                q_bank,
   input  wire logic           q_full,
   input  wire mm4_status_type status,
   output mm4_wr_type          wr
);

   logic [1:0] row_ff, row_in;
   logic       wbank_ff, wbank_in;
   logic [1:0] busy_ff, busy_in;
   logic       take;

   // hold requests while the back end owns the target bank or row 3 meets a full queue
   assign req_stall = busy_ff[wbank_ff] || ((row_ff == ROW_LAST) && q_full);
   assign take      = req_valid && !req_stall;

   always_comb begin
      row_in   = row_ff;
      wbank_in = wbank_ff;
      busy_in  = busy_ff;
      if (status.done) begin
         busy_in[status.bank] = 1'b0;
      end
      if (take) begin
         row_in = row_ff + 2'd1;
         if (row_ff == ROW_LAST) begin
            busy_in[wbank_ff] = 1'b1;
            wbank_in          = !wbank_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff   <= ROW_FIRST;
         wbank_ff <= 1'b0;
         busy_ff  <= '0;
      end else begin
         row_ff   <= row_in;
         wbank_ff <= wbank_in;
         busy_ff  <= busy_in;
      end
   end

   assign q_push = take && (row_ff == ROW_LAST);
   assign q_bank = wbank_ff;

   assign wr.we    = take;
   assign wr.bank  = wbank_ff;
   assign wr.row   = row_ff;
   assign wr.a_row = a_row;
   assign wr.b_row = b_row;

endmodule

`default_nettype wire

[sv/mm4_queue.sv]
// Two-entry job queue between front and back end; each entry names a filled bank.
// Depends on mm4_pkg.
`default_nettype none

module mm4_queue import mm4_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  wire logic push_bank,
   output logic      full,
   input  wire logic pop,
   output logic      pop_bank,
   output logic      empty
);

   localparam int QUEUE_DEPTH = 2;

   logic       q_mem_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full     = (cnt_ff == 2'(QUEUE_DEPTH));
   assign empty    = (cnt_ff == 2'd0);
   assign pop_bank = q_mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (do_pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_mem_ff[wr_ptr_ff] <= push_bank;
      end
   end

endmodule

`default_nettype wire

[sv/mm4_back.sv]
// Back end of the 4x4 matrix multiplier: banked A/B stores, sequencer, four MAC lanes,
// truncation, saturation and the result register. Depends on mm4_pkg.
`default_nettype none

module mm4_back import mm4_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire mm4_wr_type  wr,
   input  wire logic        q_empty,
   input  wire logic        q_bank,
   output logic             q_pop,
   output mm4_status_type   status,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output mm4_row_type      p_row,
   output logic [1:0]       row_index,
   output logic             last_row,
   output logic             saturated
);

   localparam logic signed [ACC_W-1:0] P_MAX = ACC_W'(32'sh7FFF_FFFF);
   localparam logic signed [ACC_W-1:0] P_MIN = ACC_W'(32'sh8000_0000);

   // stores: two banks of four rows, address {bank, row}
   mm4_row_type mem_a [2*DIM];
   mm4_row_type mem_b [2*DIM];

   logic        en;
   logic        issue, last_issue;

   logic        act_ff, act_in;
   logic        bank_ff, bank_in;
   logic [1:0]  i_ff, i_in;
   logic [1:0]  k_ff, k_in;

   mm4_row_type rd_a_ff, rd_b_ff;
   logic        s1_valid_ff;
   logic [1:0]  s1_i_ff, s1_k_ff;

   logic signed [DATA_W-1:0] a_sel;
   logic signed [PROD_W-1:0] prod_in [DIM];
   logic signed [PROD_W-1:0] prod_ff [DIM];
   logic        s2_valid_ff;
   logic [1:0]  s2_i_ff, s2_k_ff;

   logic signed [ACC_W-1:0] acc_in [DIM];
   logic signed [ACC_W-1:0] acc_ff [DIM];
   logic        acc_done_ff, acc_done_in;
   logic [1:0]  acc_i_ff;

   logic signed [ACC_W-1:0] shifted [DIM];
   logic [DIM-1:0]          clip;
   mm4_row_type             p_in;
   logic        rsp_valid_ff, rsp_valid_in;
   mm4_row_type p_ff;
   logic [1:0]  row_ff;
   logic        sat_ff;

   // whole pipeline freezes while a result waits on a stalled receiver
   assign en         = !(rsp_valid_ff && rsp_stall);
   assign q_pop      = !act_ff && !q_empty;
   assign issue      = act_ff && en;
   assign last_issue = issue && (i_ff == ROW_LAST) && (k_ff == ROW_LAST);

   assign status.active = act_ff;
   assign status.done   = last_issue;
   assign status.bank   = bank_ff;

   // sequencer: output row i, term k
   always_comb begin
      act_in  = act_ff;
      bank_in = bank_ff;
      i_in    = i_ff;
      k_in    = k_ff;
      if (q_pop) begin
         act_in  = 1'b1;
         bank_in = q_bank;
         i_in    = ROW_FIRST;
         k_in    = ROW_FIRST;
      end else if (issue) begin
         k_in = k_ff + 2'd1;
         if (k_ff == ROW_LAST) begin
            i_in = i_ff + 2'd1;
         end
         if (last_issue) begin
            act_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
      end else begin
         act_ff <= act_in;
      end
      bank_ff <= bank_in;
      i_ff    <= i_in;
      k_ff    <= k_in;
   end

   // store ports: one write from the front end, one registered read per store
   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem_a[{wr.bank, wr.row}] <= wr.a_row;
         mem_b[{wr.bank, wr.row}] <= wr.b_row;
      end
      if (issue) begin
         rd_a_ff <= mem_a[{bank_ff, i_ff}];
         rd_b_ff <= mem_b[{bank_ff, k_ff}];
      end
   end

   // multiply: element k of A's row times each element of B's row k
   assign a_sel = rd_a_ff[s1_k_ff];

   always_comb begin
      for (int j = 0; j < DIM; j++) begin
         prod_in[j] = PROD_W'(a_sel) * PROD_W'($signed(rd_b_ff[j]));
      end
   end

   // accumulate: start a fresh sum on the first term
   always_comb begin
      acc_done_in = s2_valid_ff && (s2_k_ff == ROW_LAST);
      for (int j = 0; j < DIM; j++) begin
         if (s2_k_ff == ROW_FIRST) begin
            acc_in[j] = ACC_W'(prod_ff[j]);
         end else begin
            acc_in[j] = acc_ff[j] + ACC_W'(prod_ff[j]);
         end
      end
   end

   // truncate toward minus infinity, then clip to the 32-bit range
   always_comb begin
      for (int j = 0; j < DIM; j++) begin
         shifted[j] = acc_ff[j] >>> FRAC_BITS;
         clip[j]    = (shifted[j] > P_MAX) || (shifted[j] < P_MIN);
         if (shifted[j] > P_MAX) begin
            p_in[j] = P_MAX[DATA_W-1:0];
         end else if (shifted[j] < P_MIN) begin
            p_in[j] = P_MIN[DATA_W-1:0];
         end else begin
            p_in[j] = shifted[j][DATA_W-1:0];
         end
      end
      rsp_valid_in = en ? acc_done_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         acc_done_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en) begin
            s1_valid_ff <= issue;
            s2_valid_ff <= s1_valid_ff;
            acc_done_ff <= acc_done_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_i_ff <= i_ff;
         s1_k_ff <= k_ff;
         s2_i_ff <= s1_i_ff;
         s2_k_ff <= s1_k_ff;
         prod_ff <= prod_in;
         if (s2_valid_ff) begin
            acc_ff   <= acc_in;
            acc_i_ff <= s2_i_ff;
         end
         if (acc_done_ff) begin
            p_ff   <= p_in;
            row_ff <= acc_i_ff;
            sat_ff <= |clip;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign p_row     = p_ff;
   assign row_index = row_ff;
   assign last_row  = (row_ff == ROW_LAST);
   assign saturated = sat_ff;

endmodule

`default_nettype wire

[tb/sv/matrix4x4_multiply_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the 4x4 matrix multiplier: mirrors the row stores, predicts each product row
// and compares accepted responses with it. Depends on mm4_pkg only.
module matrix4x4_multiply_checker import mm4_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic signed [DATA_W-1:0] req_a_elem0,
   input  logic signed [DATA_W-1:0] req_a_elem1,
   input  logic signed [DATA_W-1:0] req_a_elem2,
   input  logic signed [DATA_W-1:0] req_a_elem3,
   input  logic signed [DATA_W-1:0] req_b_elem0,
   input  logic signed [DATA_W-1:0] req_b_elem1,
   input  logic signed [DATA_W-1:0] req_b_elem2,
   input  logic signed [DATA_W-1:0] req_b_elem3,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic signed [DATA_W-1:0] rsp_p_elem0,
   input  logic signed [DATA_W-1:0] rsp_p_elem1,
   input  logic signed [DATA_W-1:0] rsp_p_elem2,
   input  logic signed [DATA_W-1:0] rsp_p_elem3,
   input  logic [1:0]               rsp_row_index,
   input  logic                     rsp_last_row,
   input  logic                     rsp_saturated,
   output int                       mismatches,
   output int                       rows_pending
);

   localparam logic signed [DATA_W-1:0] SAT_HIGH = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] SAT_LOW  = 32'sh8000_0000;

   typedef struct packed {
      mm4_row_type elems;
      logic [1:0]  row_no;
      logic        is_last;
      logic        clipped;
   } product_row_type;

   logic signed [DATA_W-1:0] a_rows [DIM*DIM];
   logic signed [DATA_W-1:0] b_rows [DIM*DIM];
   logic [1:0]               load_row = ROW_FIRST;
   product_row_type          rows_due [$];

   // One row of P: exact dot products, floor shift by FRAC_BITS, then clip to 32 bits
   function automatic product_row_type product_row(input int i);
      product_row_type          r;
      logic signed [ACC_W-1:0]  acc;
      logic signed [ACC_W-1:0]  lhs;
      logic signed [ACC_W-1:0]  rhs;
      logic signed [ACC_W-1:0]  scaled;
      r         = '0;
      r.row_no  = i[1:0];
      r.is_last = (i[1:0] == ROW_LAST);
      for (int j = 0; j < DIM; j++) begin
         acc = '0;
         for (int k = 0; k < DIM; k++) begin
            lhs = a_rows[i*DIM + k];
            rhs = b_rows[k*DIM + j];
            acc = acc + lhs * rhs;
         end
         scaled = acc >>> FRAC_BITS;
         if (scaled > SAT_HIGH) begin
            r.elems[j] = SAT_HIGH;
            r.clipped  = 1'b1;
         end else if (scaled < SAT_LOW) begin
            r.elems[j] = SAT_LOW;
            r.clipped  = 1'b1;
         end else begin
            r.elems[j] = scaled[DATA_W-1:0];
         end
      end
      return r;
   endfunction

   function automatic string row_text(input product_row_type r);
      return $sformatf("p=%h %h %h %h row=%0d last=%b sat=%b", r.elems[0], r.elems[1],
                       r.elems[2], r.elems[3], r.row_no, r.is_last, r.clipped);
   endfunction

   always @(posedge clock) begin
      product_row_type seen;
      product_row_type want;
      int              base;
      int              bad;
      if (reset) begin
         load_row = ROW_FIRST;
         rows_due.delete();
      end else begin
         if (req_valid && !req_stall) begin
            base = load_row * DIM;
            a_rows[base]     = req_a_elem0;
            a_rows[base + 1] = req_a_elem1;
            a_rows[base + 2] = req_a_elem2;
            a_rows[base + 3] = req_a_elem3;
            b_rows[base]     = req_b_elem0;
            b_rows[base + 1] = req_b_elem1;
            b_rows[base + 2] = req_b_elem2;
            b_rows[base + 3] = req_b_elem3;
            // the fourth row completes both matrices: queue all four product rows
            if (load_row == ROW_LAST) begin
               for (int i = 0; i < DIM; i++)
                  rows_due.push_back(product_row(i));
            end
            load_row = load_row + 2'd1;
         end
         if (rsp_valid && !rsp_stall) begin
            seen.elems[0] = rsp_p_elem0;
            seen.elems[1] = rsp_p_elem1;
            seen.elems[2] = rsp_p_elem2;
            seen.elems[3] = rsp_p_elem3;
            seen.row_no   = rsp_row_index;
            seen.is_last  = rsp_last_row;
            seen.clipped  = rsp_saturated;
            if (rows_due.size() == 0) begin
               $display("%0t ns: unexpected product row, got %s", $time, row_text(seen));
               mismatches++;
            end else begin
               want = rows_due.pop_front();
               bad  = 0;
               for (int c = 0; c < DIM; c++)
                  if (seen.elems[c] !== want.elems[c]) bad++;
               if (seen.row_no !== want.row_no) bad++;
               if (seen.is_last !== want.is_last) bad++;
               if (seen.clipped !== want.clipped) bad++;
               if (bad != 0) begin
                  $display("%0t ns: product row mismatch in %0d field(s), expected %s, got %s",
                           $time, bad, row_text(want), row_text(seen));
                  mismatches++;
               end
            end
         end
      end
      rows_pending = rows_due.size();
   end

endmodule

[tb/sv/tb_matrix4x4_multiply.sv]
`timescale 1ns / 1ps
// Top of the 4x4 matrix multiplier bench: clock, reset, request and response drivers, verdict.
// Depends on mm4_pkg, matrix4x4_multiply and matrix4x4_multiply_checker.
module tb_matrix4x4_multiply import mm4_pkg::*;;

   localparam int FRAC_BITS   = 16;
   localparam int HALF_PERIOD = 6;
   localparam int RESET_CYCLES = 8;
   // long enough for both store banks and the job queue to fill behind a frozen back end
   localparam int HOLD_CYCLES = 150;
   // extra wait after the last predicted row, to catch stray late responses
   localparam int DRAIN_CYCLES = 40;
   localparam int LIMIT_NS     = 2_000_000;

   localparam logic [DATA_W-1:0] Q_ONE     = 32'h0001_0000;
   localparam logic [DATA_W-1:0] FULL_POS  = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] FULL_NEG  = 32'h8000_0000;
   localparam logic [DATA_W-1:0] RAW_ONE   = 32'h0000_0001;
   localparam logic [DATA_W-1:0] RAW_MINUS = 32'hFFFF_FFFF;

   typedef mm4_row_type [DIM-1:0] matrix_type;

   // STEADY: no idling; BURSTY: random gaps and stalls; PRESSURE: one long response hold;
   // QUIET: closing stretch with no idling on either side
   typedef enum logic [1:0] {PH_STEADY, PH_BURSTY, PH_PRESSURE, PH_QUIET} drive_phase_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic signed [DATA_W-1:0] req_a_elem0 = '0;
   logic signed [DATA_W-1:0] req_a_elem1 = '0;
   logic signed [DATA_W-1:0] req_a_elem2 = '0;
   logic signed [DATA_W-1:0] req_a_elem3 = '0;
   logic signed [DATA_W-1:0] req_b_elem0 = '0;
   logic signed [DATA_W-1:0] req_b_elem1 = '0;
   logic signed [DATA_W-1:0] req_b_elem2 = '0;
   logic signed [DATA_W-1:0] req_b_elem3 = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [DATA_W-1:0] rsp_p_elem0;
   logic signed [DATA_W-1:0] rsp_p_elem1;
   logic signed [DATA_W-1:0] rsp_p_elem2;
   logic signed [DATA_W-1:0] rsp_p_elem3;
   logic [1:0]               rsp_row_index;
   logic                     rsp_last_row;
   logic                     rsp_saturated;
   int                       mismatches;
   int                       rows_pending;
   drive_phase_type          phase = PH_STEADY;

   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   matrix4x4_multiply #(.FRAC_BITS(FRAC_BITS)) uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_a_elem0   (req_a_elem0),
      .req_a_elem1   (req_a_elem1),
      .req_a_elem2   (req_a_elem2),
      .req_a_elem3   (req_a_elem3),
      .req_b_elem0   (req_b_elem0),
      .req_b_elem1   (req_b_elem1),
      .req_b_elem2   (req_b_elem2),
      .req_b_elem3   (req_b_elem3),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_p_elem0   (rsp_p_elem0),
      .rsp_p_elem1   (rsp_p_elem1),
      .rsp_p_elem2   (rsp_p_elem2),
      .rsp_p_elem3   (rsp_p_elem3),
      .rsp_row_index (rsp_row_index),
      .rsp_last_row  (rsp_last_row),
      .rsp_saturated (rsp_saturated)
   );

   matrix4x4_multiply_checker #(.FRAC_BITS(FRAC_BITS)) u_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_a_elem0   (req_a_elem0),
      .req_a_elem1   (req_a_elem1),
      .req_a_elem2   (req_a_elem2),
      .req_a_elem3   (req_a_elem3),
      .req_b_elem0   (req_b_elem0),
      .req_b_elem1   (req_b_elem1),
      .req_b_elem2   (req_b_elem2),
      .req_b_elem3   (req_b_elem3),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_p_elem0   (rsp_p_elem0),
      .rsp_p_elem1   (rsp_p_elem1),
      .rsp_p_elem2   (rsp_p_elem2),
      .rsp_p_elem3   (rsp_p_elem3),
      .rsp_row_index (rsp_row_index),
      .rsp_last_row  (rsp_last_row),
      .rsp_saturated (rsp_saturated),
      .mismatches    (mismatches),
      .rows_pending  (rows_pending)
   );

   // Half of them small Q16.16 values so products stay exact; the rest wide, full-range and
   // boundary values so saturation and every data bit get exercised.
   function automatic logic [DATA_W-1:0] random_elem();
      int mode;
      mode = $urandom_range(0, 9);
      if (mode < 5)
         return $urandom_range(0, 2**20 - 1) - 2**19;
      else if (mode < 7)
         return $urandom_range(0, 2**25 - 1) - 2**24;
      else if (mode < 9)
         return $urandom();
      case ($urandom_range(0, 4))
         0:       return FULL_POS;
         1:       return FULL_NEG;
         2:       return '0;
         3:       return RAW_MINUS;
         default: return Q_ONE;
      endcase
   endfunction

   function automatic matrix_type random_matrix();
      matrix_type m;
      for (int r = 0; r < DIM; r++)
         for (int c = 0; c < DIM; c++)
            m[r][c] = random_elem();
      return m;
   endfunction

   // Offer one request at the falling edge and hold it until the block takes it.
   // In the bursty phase sometimes drop valid for a random burst first.
   task automatic offer_row(input mm4_row_type a_row, input mm4_row_type b_row);
      int gap;
      @(negedge clock);
      if (phase == PH_BURSTY && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_a_elem0 <= a_row[0];
      req_a_elem1 <= a_row[1];
      req_a_elem2 <= a_row[2];
      req_a_elem3 <= a_row[3];
      req_b_elem0 <= b_row[0];
      req_b_elem1 <= b_row[1];
      req_b_elem2 <= b_row[2];
      req_b_elem3 <= b_row[3];
      req_valid   <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   // Load A and B one row pair per request, top row first
   task automatic send_matrices(input matrix_type a_mat, input matrix_type b_mat);
      for (int r = 0; r < DIM; r++)
         offer_row(a_mat[r], b_mat[r]);
   endtask

   // Response side: stall in random bursts, and once hold off for a long stretch
   // so that the front end fills both banks and has to stall requests.
   initial begin
      int  run;
      bit  stall_now;
      bit  hold_done;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (phase == PH_PRESSURE && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
            hold_done = 1'b1;
         end else if (phase == PH_BURSTY) begin
            run       = $urandom_range(1, 8);
            stall_now = ($urandom_range(0, 2) == 0);
            rsp_stall <= stall_now;
            repeat (run - 1) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      matrix_type a_mat;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, no idling: identity times random content gives the content back
      a_mat = '0;
      for (int r = 0; r < DIM; r++)
         a_mat[r][r] = Q_ONE;
      send_matrices(a_mat, random_matrix());
      // zero times full scale
      send_matrices('0, {DIM*DIM{FULL_POS}});
      // largest positive squared: every element clips high
      send_matrices({DIM*DIM{FULL_POS}}, {DIM*DIM{FULL_POS}});
      // most negative against most negative and against largest: clip high and clip low
      a_mat    = {DIM*DIM{FULL_NEG}};
      a_mat[2] = {DIM{FULL_POS}};
      a_mat[3] = {DIM{FULL_POS}};
      send_matrices(a_mat, {DIM*DIM{FULL_NEG}});
      // truncation toward minus infinity: raw -1 times raw 1 gives -1 after the shift;
      // a zero row, a one row and a large negative row that stays in range
      a_mat[0] = {DIM{RAW_MINUS}};
      a_mat[1] = '0;
      a_mat[2] = {DIM{Q_ONE}};
      a_mat[3] = {DIM{FULL_NEG}};
      send_matrices(a_mat, {DIM*DIM{RAW_ONE}});

      // Random part with gaps and stalls on both sides
      phase = PH_BURSTY;
      for (int m = 0; m < 10; m++)
         send_matrices(random_matrix(), random_matrix());

      // Keep offering back to back while the response side holds off
      phase = PH_PRESSURE;
      for (int m = 0; m < 4; m++)
         send_matrices(random_matrix(), random_matrix());

      phase = PH_BURSTY;
      for (int m = 0; m < 7; m++)
         send_matrices(random_matrix(), random_matrix());

      // Closing stretch at full rate
      phase = PH_QUIET;
      for (int m = 0; m < 4; m++)
         send_matrices(random_matrix(), random_matrix());

      @(negedge clock);
      req_valid <= 1'b0;

      // Drain: wait for every predicted row, then allow for stray late responses
      wait (rows_pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && rows_pending == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // Watchdog
   initial begin
      #(LIMIT_NS);
      $display("TB_ERROR");
      $finish;
   end

endmodule

[sim.f]
+incdir+sv
sv/mm4_pkg.sv
sv/mm4_front.sv
sv/mm4_queue.sv
sv/mm4_back.sv
sv/matrix4x4_multiply.sv
tb/sv/matrix4x4_multiply_checker.sv
tb/sv/tb_matrix4x4_multiply.sv
